// ===== rtl/core/jstc_pkg.sv =====
package jstc_pkg;

   // Default sizes
   localparam int POS_BITS_DEF       = 24;
   localparam int FRAMES_PER_SEC_DEF = 30;

   // Request types
   localparam logic [1:0] REQ_WHEEL  = 2'd0;
   localparam logic [1:0] REQ_BUTTON = 2'd1;
   localparam logic [1:0] REQ_RESET  = 2'd2;

   // Button codes
   localparam logic [2:0] BTN_SET   = 3'd5;
   localparam logic [2:0] BTN_LEFT  = 3'd6;
   localparam logic [2:0] BTN_RIGHT = 3'd7;
   localparam logic [2:0] BTN_LAST_TRANSPORT = 3'd4;

   // Command kinds
   localparam logic [3:0] CMD_STEP      = 4'd0;
   localparam logic [3:0] CMD_SHUTTLE   = 4'd1;
   localparam logic [3:0] CMD_LOCATE    = 4'd2;
   localparam logic [3:0] CMD_STOP      = 4'd3;
   localparam logic [3:0] CMD_PLAY      = 4'd4;
   localparam logic [3:0] CMD_FFWD      = 4'd5;
   localparam logic [3:0] CMD_REWIND    = 4'd6;
   localparam logic [3:0] CMD_REC_STROBE = 4'd7;
   localparam logic [3:0] CMD_REC_EXIT  = 4'd8;
   localparam logic [3:0] CMD_REC_PAUSE = 4'd9;
   localparam logic [3:0] CMD_LIGHTS    = 4'd10;

   // Transport bits
   localparam logic [4:0] TB_STOP = 5'h01;
   localparam logic [4:0] TB_PLAY = 5'h02;
   localparam logic [4:0] TB_REW  = 5'h04;
   localparam logic [4:0] TB_FFWD = 5'h08;
   localparam logic [4:0] TB_REC  = 5'h10;

   localparam logic [7:0] LOCATE_SUBCODE = 8'h01;
   localparam logic signed [9:0] SPEED_LIMIT = 10'sd63;

   // Work handed from front to back
   typedef enum logic [1:0] {
      OP_ONE,
      OP_WITH_LIGHTS,
      OP_LOCATE,
      OP_LIGHTS_LOCATE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] kind;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [3:0] lamps;
   } hdr_type;

endpackage

// ===== rtl/core/jstc_queue.sv =====
module jstc_queue
   import jstc_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/jstc_front.sv =====
module jstc_front
   import jstc_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_type,
   input  logic [7:0]          wheel_pos,
   input  logic [2:0]          button_id,
   input  logic                button_level,
   output logic                push,
   output hdr_type             hdr,
   output logic [POS_BITS-1:0] frames
);

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   logic [7:0]          prev_ff, prev_in;
   logic [POS_BITS-1:0] abs_ff, abs_in, left_ff, left_in, right_ff, right_in;
   logic signed [7:0]   speed_ff, speed_in;
   logic                set_ff, set_in;
   logic [4:0]          tb_ff, tb_in;

   logic signed [9:0]          diff;
   logic signed [POS_BITS+1:0] pos_sum;
   logic [POS_BITS-1:0]        pos_new;
   logic signed [9:0]          spd_sum, spd_clamp;
   logic [5:0]                 mag;
   logic [5:0]                 neg_d;
   logic [4:0]                 tmask, tb_tog;
   logic [3:0]                 tkind;
   logic [3:0]                 lamps;
   logic signed [7:0]          lspeed;

   // Wrapped wheel delta, clamped position and clamped shuttle speed
   always_comb begin
      diff = $signed({2'b00, wheel_pos}) - $signed({2'b00, prev_ff});
      if (diff > 10'sd127) begin
         diff = diff - 10'sd255;
      end else if (diff < -10'sd127) begin
         diff = diff + 10'sd255;
      end
      pos_sum = $signed({2'b00, abs_ff}) + $signed({{(POS_BITS - 8){diff[9]}}, diff});
      if (pos_sum < 0) begin
         pos_new = '0;
      end else if (pos_sum > $signed({2'b00, POS_MAX})) begin
         pos_new = POS_MAX;
      end else begin
         pos_new = pos_sum[POS_BITS-1:0];
      end
      spd_sum = $signed({{2{speed_ff[7]}}, speed_ff}) + diff;
      if (spd_sum > SPEED_LIMIT) begin
         spd_clamp = SPEED_LIMIT;
      end else if (spd_sum < -SPEED_LIMIT) begin
         spd_clamp = -SPEED_LIMIT;
      end else begin
         spd_clamp = spd_sum;
      end
      mag   = spd_clamp[9] ? 6'(-spd_clamp) : spd_clamp[5:0];
      neg_d = 6'(-diff);
   end

   // Toggle transport state
   always_comb begin
      tmask = 5'(5'b00001 << button_id);
      tkind = CMD_STOP;
      if (tmask == TB_PLAY) begin
         if ((tb_ff & TB_PLAY) != '0) begin
            tb_tog = TB_STOP;
            tkind  = CMD_STOP;
         end else begin
            tb_tog = (tb_ff & TB_REC) | TB_PLAY;
            tkind  = CMD_PLAY;
         end
      end else if (tmask == TB_REC) begin
         if ((tb_ff & TB_REC) != '0) begin
            tb_tog = tb_ff & ~TB_REC;
            tkind  = CMD_REC_EXIT;
         end else begin
            tb_tog = (tb_ff & TB_PLAY) | TB_REC;
            tkind  = ((tb_ff & TB_PLAY) != '0) ? CMD_REC_STROBE : CMD_REC_PAUSE;
         end
      end else begin
         tb_tog = ((tb_ff & tmask) != '0) ? TB_STOP : tmask;
         if ((tb_tog & TB_STOP) != '0) begin
            tkind = CMD_STOP;
         end else if ((tb_tog & TB_REW) != '0) begin
            tkind = CMD_REWIND;
         end else begin
            tkind = CMD_FFWD;
         end
      end
      // Lights and speed preset from the new state
      lamps = {tb_tog[3], tb_tog[2], tb_tog[4], tb_tog[1]};
      if (tb_tog[1]) begin
         lspeed = 8'sd8;
      end else if (tb_tog[2]) begin
         lspeed = -8'sd64;
      end else if (tb_tog[3]) begin
         lspeed = 8'sd64;
      end else begin
         lspeed = 8'sd0;
      end
   end

   // Classify the beat and update state
   always_comb begin
      prev_in  = prev_ff;
      abs_in   = abs_ff;
      left_in  = left_ff;
      right_in = right_ff;
      speed_in = speed_ff;
      set_in   = set_ff;
      tb_in    = tb_ff;
      push     = 1'b0;
      hdr      = '{op: OP_ONE, kind: CMD_STEP, byte_a: 8'h00, byte_b: 8'h00, lamps: 4'h0};
      frames   = abs_ff;
      if (accept) begin
         case (req_type)
            REQ_WHEEL: begin
               prev_in = wheel_pos;
               abs_in  = pos_new;
               push    = 1'b1;
               if (speed_ff != 8'sd0) begin
                  speed_in    = spd_clamp[7:0];
                  hdr.kind    = CMD_SHUTTLE;
                  hdr.byte_a  = {1'b0, spd_clamp[9], 3'b000, mag[5:3]};
                  hdr.byte_b  = {1'b0, mag[2:0], 4'h0};
               end else if (diff[9]) begin
                  hdr.byte_a = {2'b01, neg_d[4:0], 1'b0};
               end else begin
                  hdr.byte_a = {2'b00, diff[4:0], 1'b0};
               end
            end
            REQ_BUTTON: begin
               if (button_id <= BTN_LAST_TRANSPORT) begin
                  if (button_level) begin
                     tb_in     = tb_tog;
                     speed_in  = lspeed;
                     push      = 1'b1;
                     hdr.op    = OP_WITH_LIGHTS;
                     hdr.kind  = tkind;
                     hdr.lamps = lamps;
                  end
               end else if (button_id == BTN_SET) begin
                  set_in = button_level;
               end else if (button_level) begin
                  if (set_ff) begin
                     if (button_id == BTN_LEFT) begin
                        left_in = abs_ff;
                     end else begin
                        right_in = abs_ff;
                     end
                  end else begin
                     abs_in = (button_id == BTN_LEFT) ? left_ff : right_ff;
                     frames = abs_in;
                     push   = 1'b1;
                     hdr.op = OP_LOCATE;
                  end
               end
            end
            REQ_RESET: begin
               prev_in  = '0;
               abs_in   = '0;
               left_in  = '0;
               right_in = '0;
               speed_in = '0;
               set_in   = 1'b0;
               tb_in    = '0;
               frames   = '0;
               push     = 1'b1;
               hdr.op   = OP_LIGHTS_LOCATE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         abs_ff   <= '0;
         left_ff  <= '0;
         right_ff <= '0;
         speed_ff <= '0;
         set_ff   <= 1'b0;
         tb_ff    <= '0;
      end else begin
         prev_ff  <= prev_in;
         abs_ff   <= abs_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         speed_ff <= speed_in;
         set_ff   <= set_in;
         tb_ff    <= tb_in;
      end
   end

endmodule

// ===== rtl/core/jstc_back.sv =====
module jstc_back
   import jstc_pkg::*;
#(
   parameter int POS_BITS       = POS_BITS_DEF,
   parameter int FRAMES_PER_SEC = FRAMES_PER_SEC_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hdr_type             q_hdr,
   input  logic [POS_BITS-1:0] q_frames,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_cmd_kind,
   output logic [7:0]          rsp_byte_a,
   output logic [7:0]          rsp_byte_b,
   output logic [7:0]          rsp_byte_c,
   output logic [7:0]          rsp_byte_d,
   output logic [7:0]          rsp_byte_e,
   output logic [7:0]          rsp_byte_f,
   output logic [3:0]          rsp_lamps,
   output logic                rsp_last
);

   localparam int PW = 2 * POS_BITS;
   localparam logic [POS_BITS-1:0] PER_HOUR = POS_BITS'(3600 * FRAMES_PER_SEC);
   localparam logic [POS_BITS-1:0] PER_MIN  = POS_BITS'(60 * FRAMES_PER_SEC);
   localparam logic [POS_BITS-1:0] PER_SEC  = POS_BITS'(FRAMES_PER_SEC);
   // Reciprocals scaled by 2^POS_BITS, rounded down
   localparam logic [POS_BITS-1:0] RCP_HOUR =
      POS_BITS'((64'd1 << POS_BITS) / (3600 * FRAMES_PER_SEC));
   localparam logic [POS_BITS-1:0] RCP_MIN  =
      POS_BITS'((64'd1 << POS_BITS) / (60 * FRAMES_PER_SEC));
   localparam logic [POS_BITS-1:0] RCP_SEC  =
      POS_BITS'((64'd1 << POS_BITS) / FRAMES_PER_SEC);

   typedef enum logic [1:0] {S_IDLE, S_LIGHTS, S_DIV, S_LOCOUT} state_type;

   state_type           state_ff;
   logic                valid_ff;
   logic [3:0]          kind_ff;
   logic [7:0]          a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [3:0]          lamps_ff, hold_lamps_ff;
   logic                last_ff;
   logic [POS_BITS-1:0] num_ff, quo_ff, rem_ff;
   logic [1:0]          phase_ff, step_ff;
   logic [7:0]          hh_ff, mm_ff, ss_ff, fr_ff;

   logic                out_free;
   logic [POS_BITS-1:0] divisor, recip, back_mul, quo_fix, rem_fix;
   logic [PW-1:0]       prod;
   logic                fix;

   assign out_free = !valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == S_IDLE) && q_valid && out_free;

   // Estimate the quotient by reciprocal, then correct it by at most one
   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            divisor = PER_HOUR;
            recip   = RCP_HOUR;
         end
         2'd1: begin
            divisor = PER_MIN;
            recip   = RCP_MIN;
         end
         default: begin
            divisor = PER_SEC;
            recip   = RCP_SEC;
         end
      endcase
      prod     = PW'(num_ff) * PW'(recip);
      back_mul = quo_ff * divisor;
      fix      = (rem_ff >= divisor);
      quo_fix  = quo_ff + POS_BITS'(fix);
      rem_fix  = fix ? rem_ff - divisor : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  valid_ff <= (q_hdr.op == OP_ONE) || (q_hdr.op == OP_WITH_LIGHTS)
                              || (q_hdr.op == OP_LIGHTS_LOCATE);
                  kind_ff  <= (q_hdr.op == OP_LIGHTS_LOCATE) ? CMD_LIGHTS : q_hdr.kind;
                  a_ff     <= (q_hdr.op == OP_LIGHTS_LOCATE) ? 8'h00 : q_hdr.byte_a;
                  b_ff     <= (q_hdr.op == OP_LIGHTS_LOCATE) ? 8'h00 : q_hdr.byte_b;
                  c_ff     <= 8'h00;
                  d_ff     <= 8'h00;
                  e_ff     <= 8'h00;
                  lamps_ff <= 4'h0;
                  last_ff  <= (q_hdr.op == OP_ONE);
                  hold_lamps_ff <= q_hdr.lamps;
                  num_ff   <= q_frames;
                  step_ff  <= 2'd0;
                  phase_ff <= 2'd0;
                  unique case (q_hdr.op)
                     OP_ONE:         state_ff <= S_IDLE;
                     OP_WITH_LIGHTS: state_ff <= S_LIGHTS;
                     default:        state_ff <= S_DIV;
                  endcase
               end else if (!rsp_stall) begin
                  valid_ff <= 1'b0;
               end
            end
            S_LIGHTS: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= CMD_LIGHTS;
                  a_ff     <= 8'h00;
                  b_ff     <= 8'h00;
                  lamps_ff <= hold_lamps_ff;
                  last_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               // Drain any waiting beat while the digits are worked out
               if (!rsp_stall) begin
                  valid_ff <= 1'b0;
               end
               unique case (step_ff)
                  2'd0: begin
                     quo_ff  <= prod[PW-1:POS_BITS];
                     step_ff <= 2'd1;
                  end
                  2'd1: begin
                     rem_ff  <= num_ff - back_mul;
                     step_ff <= 2'd2;
                  end
                  default: begin
                     step_ff  <= 2'd0;
                     num_ff   <= rem_fix;
                     phase_ff <= phase_ff + 1'b1;
                     unique case (phase_ff)
                        2'd0: hh_ff <= quo_fix[7:0];
                        2'd1: mm_ff <= quo_fix[7:0];
                        default: begin
                           ss_ff    <= quo_fix[7:0];
                           fr_ff    <= rem_fix[7:0];
                           state_ff <= S_LOCOUT;
                        end
                     endcase
                  end
               endcase
            end
            S_LOCOUT: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= CMD_LOCATE;
                  a_ff     <= LOCATE_SUBCODE;
                  b_ff     <= hh_ff;
                  c_ff     <= mm_ff;
                  d_ff     <= ss_ff;
                  e_ff     <= fr_ff;
                  lamps_ff <= 4'h0;
                  last_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_cmd_kind = kind_ff;
   assign rsp_byte_a   = a_ff;
   assign rsp_byte_b   = b_ff;
   assign rsp_byte_c   = c_ff;
   assign rsp_byte_d   = d_ff;
   assign rsp_byte_e   = e_ff;
   assign rsp_byte_f   = 8'h00;
   assign rsp_lamps    = lamps_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== rtl/core/jog_shuttle_transport_control.sv =====
// Jog wheel and transport button controller. Each request beat (wheel sample,
// button event or reset) is taken while the two-entry work queue has room;
// the front updates position, marks, shuttle speed and transport state at once
// and queues any reply. The back sends one result beat per cycle, while the
// output is not stalled, for step, shuttle, transport and lights replies, so a
// transport press gives two beats on the output. A locate reply first splits
// the position into hours, minutes, seconds and frames: for each digit a
// reciprocal multiply estimates the quotient, a multiply back gives the
// remainder and one correction fixes both; its beat is then sent, and requests
// keep being taken meanwhile until the queue fills.
module jog_shuttle_transport_control
   import jstc_pkg::*;
#(
   parameter int POS_BITS       = POS_BITS_DEF,
   parameter int FRAMES_PER_SEC = FRAMES_PER_SEC_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_wheel_pos,
   input  logic [2:0] req_button_id,
   input  logic       req_button_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_cmd_kind,
   output logic [7:0] rsp_byte_a,
   output logic [7:0] rsp_byte_b,
   output logic [7:0] rsp_byte_c,
   output logic [7:0] rsp_byte_d,
   output logic [7:0] rsp_byte_e,
   output logic [7:0] rsp_byte_f,
   output logic [3:0] rsp_lamp_bits,
   output logic       rsp_last_of_run
);

   localparam int HW = $bits(hdr_type);
   localparam int QW = HW + POS_BITS;

   logic                q_full, q_push, q_pop, q_valid, accept;
   hdr_type             f_hdr, b_hdr;
   logic [POS_BITS-1:0] f_frames, b_frames;
   logic [QW-1:0]       q_out;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   jstc_front #(.POS_BITS(POS_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .wheel_pos    (req_wheel_pos),
      .button_id    (req_button_id),
      .button_level (req_button_level),
      .push         (q_push),
      .hdr          (f_hdr),
      .frames       (f_frames)
   );

   jstc_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_hdr, f_frames}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   assign b_hdr    = hdr_type'(q_out[QW-1:POS_BITS]);
   assign b_frames = q_out[POS_BITS-1:0];

   jstc_back #(.POS_BITS(POS_BITS), .FRAMES_PER_SEC(FRAMES_PER_SEC)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_hdr        (b_hdr),
      .q_frames     (b_frames),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cmd_kind (rsp_cmd_kind),
      .rsp_byte_a   (rsp_byte_a),
      .rsp_byte_b   (rsp_byte_b),
      .rsp_byte_c   (rsp_byte_c),
      .rsp_byte_d   (rsp_byte_d),
      .rsp_byte_e   (rsp_byte_e),
      .rsp_byte_f   (rsp_byte_f),
      .rsp_lamps    (rsp_lamp_bits),
      .rsp_last     (rsp_last_of_run)
   );

   // Queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full || q_pop)
      else $error("work queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("work queue underflow");

   // Locate beats carry their sub-code and end the run
   a_locate_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_kind == CMD_LOCATE |-> rsp_byte_a == LOCATE_SUBCODE
         && rsp_last_of_run)
      else $error("malformed locate beat");

endmodule
